>>> hw/rtl/mf2d_pkg.sv
// Package with the shared types and constants of the minifloat to double converter.
package mf2d_pkg;

  localparam int unsigned KeptFracBits = 13;
  localparam logic [10:0] DblBias = 11'd1023;
  localparam logic [63:0] DblQnan = 64'h7FF8_0000_0000_0000;

  typedef enum logic [2:0] {
    ClassZero      = 3'd0,
    ClassSubnormal = 3'd1,
    ClassNormal    = 3'd2,
    ClassInf       = 3'd3,
    ClassNan       = 3'd4
  } value_class_e;

  typedef struct packed {
    logic [63:0]  double_bits;
    value_class_e value_class;
  } result_t;

endpackage

>>> hw/rtl/mf2d_decode.sv
// Combinational decode of one minifloat item into a binary64 pattern and class.
module mf2d_decode (
  input  logic [2:0]        size_i,
  input  logic [31:0]       raw_i,
  output mf2d_pkg::result_t res_o
);

  logic [2:0]  s;
  logic        sign;
  logic [9:0]  e, eall;
  logic [22:0] f;
  logic [4:0]  fbits;
  logic [9:0]  bias;
  logic [23:0] m;
  logic [9:0]  rem, half;
  logic [12:0] keep;
  logic        rnd;
  logic [4:0]  p;
  logic [10:0] de;
  logic [51:0] frac;
  logic [63:0] fw;

  always_comb begin
    s = size_i;
    if (s == 3'd0) s = 3'd1;
    if (s > 3'd4) s = 3'd4;
    sign = 1'b0; e = '0; f = '0; eall = '0; fbits = '0; bias = '0;
    rem = '0; half = '0; keep = '0; rnd = 1'b0; m = '0; de = '0;
    case (s)
      3'd1: begin
        sign = raw_i[7]; e = {6'd0, raw_i[6:3]}; f = {20'd0, raw_i[2:0]};
        eall = 10'h00F; fbits = 5'd3; bias = 10'd7;
      end
      3'd2: begin
        sign = raw_i[15]; e = {4'd0, raw_i[14:9]}; f = {14'd0, raw_i[8:0]};
        eall = 10'h03F; fbits = 5'd9; bias = 10'd31;
      end
      3'd3: begin
        sign = raw_i[23]; e = {2'd0, raw_i[22:15]}; f = {8'd0, raw_i[14:0]};
        eall = 10'h0FF; fbits = 5'd15; bias = 10'd127;
        keep = raw_i[14:2]; rem = {8'd0, raw_i[1:0]}; half = 10'd2;
      end
      default: begin
        sign = raw_i[31]; e = raw_i[30:21]; f = {2'd0, raw_i[20:0]};
        eall = 10'h3FF; fbits = 5'd21; bias = 10'd511;
        keep = raw_i[20:8]; rem = {2'd0, raw_i[7:0]}; half = 10'd128;
      end
    endcase
    // Round to 13 fraction bits, nearest even; the carry may reach the exponent.
    if (s >= 3'd3 && e != eall) begin
      rnd = (rem > half) || (rem == half && keep[0]);
      m = {1'b0, e, keep} + {23'd0, rnd};
      e = m[22:13];
      f = {10'd0, m[12:0]};
      fbits = 5'(mf2d_pkg::KeptFracBits);
    end
    p = '0;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) p = 5'(i);
    end
    fw = {41'd0, f} << (6'd52 - {1'b0, p});
    frac = fw[51:0];
    res_o.double_bits = '0;
    res_o.value_class = mf2d_pkg::ClassZero;
    if (e == eall) begin
      if (f == '0) begin
        res_o.double_bits = {sign, 11'h7FF, 52'd0};
        res_o.value_class = mf2d_pkg::ClassInf;
      end else begin
        res_o.double_bits = mf2d_pkg::DblQnan;
        res_o.value_class = mf2d_pkg::ClassNan;
      end
    end else if (e == '0) begin
      if (f == '0) begin
        res_o.double_bits = {sign, 63'd0};
      end else begin
        de = mf2d_pkg::DblBias + {6'd0, p} + 11'd1 - {1'b0, bias} - {6'd0, fbits};
        res_o.double_bits = {sign, de, frac};
        res_o.value_class = mf2d_pkg::ClassSubnormal;
      end
    end else begin
      de = {1'b0, e} + mf2d_pkg::DblBias - {1'b0, bias};
      fw = {41'd0, f} << (6'd52 - {1'b0, fbits});
      res_o.double_bits = {sign, de, fw[51:0]};
      res_o.value_class = mf2d_pkg::ClassNormal;
    end
  end

endmodule

>>> hw/rtl/minifloat_to_double_core.sv
// Top level of the minifloat to binary64 converter.
//
//  Channel  Direction  Handshake              Payload
//  cfg      in         cfg_valid/cfg_ready    type_size (3 bits)
//  s_axis   in         tvalid/tready          tdata: raw_value [31:0]
//  m_axis   out        tvalid/tready          tdata: double_bits [63:0]; tuser: value_class [2:0]
//
// Each item is registered at the input, decoded by combinational logic, and
// held in the result register; one item per cycle is sustained while the output
// is not stalled, set by the single decode stage between the two registers.
// A result is offered from the result register after passing the input register
// and the decode logic, so an item is never accepted and delivered on the same edge.
// Reset clears the valid flags and sets type_size to 4. When the output is
// stalled, both stages hold and the input stops accepting once both are full.
module minifloat_to_double_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // raw_value [31:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // double_bits [63:0]
  output logic [2:0]  m_axis_tuser_o    // value_class [2:0]
);

  logic [2:0]        size_q;
  logic [31:0]       raw_q;
  logic              in_vld_q, out_vld_q;
  mf2d_pkg::result_t res_d, res_q;
  logic              out_load, in_load;

  assign cfg_ready_o = 1'b1;

  // The output register loads when empty or drained this cycle.
  assign out_load = !out_vld_q || m_axis_tready_i;
  // The input register can take an item when it moves on or is empty.
  assign s_axis_tready_o = !in_vld_q || out_load;
  assign in_load = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= 3'd4;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) size_q <= cfg_data_i;
      if (s_axis_tready_o) in_vld_q <= s_axis_tvalid_i;
      if (out_load) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) raw_q <= s_axis_tdata_i;
    if (out_load && in_vld_q) res_q <= res_d;
  end

  mf2d_decode u_decode (
    .size_i(size_q),
    .raw_i (raw_q),
    .res_o (res_d)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = res_q.double_bits;
  assign m_axis_tuser_o  = res_q.value_class;

endmodule

>>> hw/rtl/mf2d_checker.sv
// Port-level checker for the minifloat to binary64 converter, bound to the top level.
module mf2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= mf2d_pkg::ClassNan)
    else $error("bad value class");

  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == mf2d_pkg::ClassNan |->
      m_axis_tdata_o == mf2d_pkg::DblQnan)
    else $error("NaN not canonical");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

endmodule

bind minifloat_to_double_core mf2d_checker u_mf2d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
